### src/ssr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the stream search-and-replace block
// Beat payloads, configuration register indexes and the burst command that
// travels from the classify front end to the byte emitter.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int MAX_SEARCH_DEF  = 8;
    localparam int MAX_REPLACE_DEF = 8;

    // Widest burst one input beat can cause (window flush or replacement)
    localparam int BURST_MAX   = 8;
    localparam int BURST_LEN_W = $clog2(BURST_MAX + 1);
    localparam int BURST_IDX_W = $clog2(BURST_MAX);

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CMD_DEPTH  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH_PATTERN = 2'd0,
        CFG_SEARCH_LEN     = 2'd1,
        CFG_REPLACE_BYTES  = 2'd2,
        CFG_REPLACE_LEN    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_end;
    } out_item_t;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [BURST_LEN_W-1:0]    len;
        logic                      last;
    } burst_t;

endpackage

### src/ssr_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_cmd_fifo: burst command queue
// Short register queue between the classify front end and the byte emitter.
// ----------------------------------------------------------------------------
module ssr_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  ssr_pkg::burst_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output ssr_pkg::burst_t rd_data,
    output logic            empty
);
    import ssr_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    burst_t             mem_reg [CMD_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(CMD_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/ssr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_front: lookahead window and match classification
// Holds the configuration and the pending-byte window, and turns each input
// beat into at most one burst command: a replacement, the oldest byte, or a
// flush of the whole window.
// ----------------------------------------------------------------------------
module ssr_front #(
    parameter int MAX_SEARCH  = ssr_pkg::MAX_SEARCH_DEF,
    parameter int MAX_REPLACE = ssr_pkg::MAX_REPLACE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  ssr_pkg::cfg_index_t           cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ssr_pkg::in_item_t             s_data,
    input  logic                          cmd_full,
    output logic                          cmd_push,
    output ssr_pkg::burst_t               cmd_data
);
    import ssr_pkg::*;

    localparam int SLEN_W = $clog2(MAX_SEARCH + 1);
    localparam int RLEN_W = $clog2(MAX_REPLACE + 1);

    logic [MAX_SEARCH*8-1:0]       pattern_reg, pattern_next;
    logic [SLEN_W-1:0]             slen_reg, slen_next;
    logic [MAX_REPLACE*8-1:0]      repl_reg, repl_next;
    logic [RLEN_W-1:0]             rlen_reg, rlen_next;
    logic [MAX_SEARCH-1:0][7:0]    win_reg, win_next;
    logic [SLEN_W-1:0]             cnt_reg, cnt_next;

    logic [MAX_SEARCH-1:0][7:0]    win_push;
    logic [MAX_SEARCH-1:0][7:0]    win_shift;
    logic [BURST_MAX-1:0][7:0]     win_burst;
    logic [BURST_MAX-1:0][7:0]     repl_burst;
    logic [SLEN_W-1:0]             new_cnt;
    logic [3:0]                    cfg_len;
    logic                          pass, full, hit, accept, emit;

    assign s_ready  = !cmd_full;
    assign accept   = s_valid && s_ready;
    assign cmd_push = accept && emit;
    assign cfg_len  = cfg_wdata[3:0];

    // Window with the new byte appended at the fill position
    always_comb begin
        for (int i = 0; i < MAX_SEARCH; i++) begin
            win_push[i] = (SLEN_W'(i) == cnt_reg) ? s_data.text_byte : win_reg[i];
        end
        for (int i = 0; i < MAX_SEARCH - 1; i++) begin
            win_shift[i] = win_push[i + 1];
        end
        win_shift[MAX_SEARCH-1] = 8'h00;
    end

    for (genvar g = 0; g < BURST_MAX; g++) begin : g_burst
        if (g < MAX_SEARCH) begin : g_win
            assign win_burst[g] = win_push[g];
        end else begin : g_win_pad
            assign win_burst[g] = 8'h00;
        end
        if (g < MAX_REPLACE) begin : g_repl
            assign repl_burst[g] = repl_reg[8*g +: 8];
        end else begin : g_repl_pad
            assign repl_burst[g] = 8'h00;
        end
    end

    assign new_cnt = cnt_reg + 1'b1;
    assign pass    = (slen_reg == '0) || (rlen_reg == '0);
    assign full    = (new_cnt >= slen_reg);

    always_comb begin
        hit = 1'b1;
        for (int i = 0; i < MAX_SEARCH; i++) begin
            if ((SLEN_W'(i) < slen_reg) && (win_push[i] != pattern_reg[8*i +: 8])) begin
                hit = 1'b0;
            end
        end
    end

    // Classify the beat
    always_comb begin
        emit          = 1'b0;
        cmd_data      = '0;
        cmd_data.last = s_data.text_end;
        win_next      = win_reg;
        cnt_next      = cnt_reg;
        priority if (pass) begin
            emit           = 1'b1;
            cmd_data.bytes = win_burst;
            cmd_data.len   = BURST_LEN_W'(new_cnt);
            cnt_next       = '0;
        end else if (full && hit) begin
            emit           = 1'b1;
            cmd_data.bytes = repl_burst;
            cmd_data.len   = BURST_LEN_W'(rlen_reg);
            cnt_next       = '0;
        end else if (s_data.text_end) begin
            emit           = 1'b1;
            cmd_data.bytes = win_burst;
            cmd_data.len   = BURST_LEN_W'(new_cnt);
            cnt_next       = '0;
        end else if (full) begin
            // Miss: release the oldest byte, slide the window
            emit           = 1'b1;
            cmd_data.bytes = win_burst;
            cmd_data.len   = BURST_LEN_W'(1);
            win_next       = win_shift;
            cnt_next       = new_cnt - 1'b1;
        end else begin
            win_next = win_push;
            cnt_next = new_cnt;
        end
    end

    // Configuration writes, lengths clamped to the window sizes
    always_comb begin
        pattern_next = pattern_reg;
        slen_next    = slen_reg;
        repl_next    = repl_reg;
        rlen_next    = rlen_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SEARCH_PATTERN: pattern_next = cfg_wdata[MAX_SEARCH*8-1:0];
                CFG_SEARCH_LEN:
                    slen_next = (int'(cfg_len) > MAX_SEARCH) ? SLEN_W'(MAX_SEARCH)
                                                             : SLEN_W'(cfg_len);
                CFG_REPLACE_BYTES:  repl_next = cfg_wdata[MAX_REPLACE*8-1:0];
                CFG_REPLACE_LEN:
                    rlen_next = (int'(cfg_len) > MAX_REPLACE) ? RLEN_W'(MAX_REPLACE)
                                                              : RLEN_W'(cfg_len);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            slen_reg    <= '0;
            repl_reg    <= '0;
            rlen_reg    <= '0;
            cnt_reg     <= '0;
        end else begin
            pattern_reg <= pattern_next;
            slen_reg    <= slen_next;
            repl_reg    <= repl_next;
            rlen_reg    <= rlen_next;
            // Drop pending bytes on a new search length
            if (cfg_wr_en && cfg_index == CFG_SEARCH_LEN) begin
                cnt_reg <= '0;
            end else if (accept) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

endmodule

### src/ssr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_back: burst serializer
// Walks the burst at the head of the command queue one byte per beat into the
// output register and pops the command as it loads its final byte.
// ----------------------------------------------------------------------------
module ssr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  ssr_pkg::burst_t    cmd_data,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ssr_pkg::out_item_t m_data
);
    import ssr_pkg::*;

    logic [BURST_IDX_W-1:0] idx_reg, idx_next;
    logic                   valid_reg, valid_next;
    out_item_t              data_reg, data_next;
    logic                   load, last_byte;

    assign load      = !cmd_empty && (!valid_reg || m_ready);
    assign last_byte = ({1'b0, idx_reg} == (cmd_data.len - 1'b1));
    assign cmd_pop   = load && last_byte;
    assign m_valid   = valid_reg;
    assign m_data    = data_reg;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next         = 1'b1;
            data_next.out_byte = cmd_data.bytes[idx_reg];
            data_next.out_end  = cmd_data.last && last_byte;
            idx_next           = last_byte ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

### src/stream_search_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_search_replace: byte stream search and replace
// Replaces each leftmost, non-overlapping occurrence of a search pattern in a
// byte stream with a replacement string.
// ----------------------------------------------------------------------------
// Takes one text byte per beat and delivers one output byte per cycle while
// m_ready holds. The front end classifies each byte against a lookahead
// window in the cycle it is accepted and queues one burst command (two
// entries deep); the back end emits that burst one byte per cycle while
// m_ready holds. Plain bytes therefore stream at one per cycle, while a
// match (replace_len bytes) or an end-of-text flush (up to MAX_SEARCH bytes)
// holds off input once the command queue is full. Each burst is registered in
// the queue before the back end loads its first byte into the output register.
// Lengths above MAX_SEARCH / MAX_REPLACE are clamped; writing search_len drops
// any pending window bytes. Configure only while the block is idle.
module stream_search_replace #(
    parameter int MAX_SEARCH  = ssr_pkg::MAX_SEARCH_DEF,
    parameter int MAX_REPLACE = ssr_pkg::MAX_REPLACE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  ssr_pkg::cfg_index_t            cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ssr_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ssr_pkg::out_item_t             m_data
);
    import ssr_pkg::*;

    burst_t push_data, head_data;
    logic   push, q_full, q_empty, pop;

    ssr_front #(
        .MAX_SEARCH (MAX_SEARCH),
        .MAX_REPLACE(MAX_REPLACE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cmd_full (q_full),
        .cmd_push (push),
        .cmd_data (push_data)
    );

    ssr_cmd_fifo u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (push),
        .wr_data(push_data),
        .full   (q_full),
        .rd_en  (pop),
        .rd_data(head_data),
        .empty  (q_empty)
    );

    ssr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_data (head_data),
        .cmd_empty(q_empty),
        .cmd_pop  (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

### dv/ssr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_checker: scoreboard for the stream search-and-replace block
// Watches the register port and both beat channels, rewrites every accepted
// text byte with its own copy of the lookahead window and registers, queues
// the output beats that byte must cause and checks each output beat, field by
// field, against the oldest one waiting.
// ----------------------------------------------------------------------------
module ssr_checker
    import ssr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    output int                    mismatch_count,
    output int                    bytes_outstanding
);

    localparam int WIN_DEPTH = MAX_SEARCH_DEF;

    logic [63:0] pattern_r;
    logic [63:0] replace_r;
    logic [3:0]  slen_r;
    logic [3:0]  rlen_r;
    logic [7:0]  win [WIN_DEPTH];
    int          win_fill;

    out_item_t   burst_q[$];
    out_item_t   rewritten_q[$];

    task automatic put_byte(input logic [7:0] b);
        out_item_t beat;
        beat.out_byte = b;
        beat.out_end  = 1'b0;
        burst_q.push_back(beat);
    endtask

    task automatic drop_oldest(input int k);
        int i;
        if (k > win_fill) k = win_fill;
        for (i = 0; i + k < win_fill; i++) win[i] = win[i + k];
        win_fill -= k;
    endtask

    task automatic flush_window();
        int i;
        for (i = 0; i < win_fill; i++) put_byte(win[i]);
        win_fill = 0;
    endtask

    // Rewrite one text byte and queue the output beats it causes.
    task automatic rewrite_byte(input in_item_t item);
        int   slen;
        int   rlen;
        int   i;
        logic hit;
        slen = (slen_r > WIN_DEPTH) ? WIN_DEPTH : int'(slen_r);
        rlen = (rlen_r > MAX_REPLACE_DEF) ? MAX_REPLACE_DEF : int'(rlen_r);
        burst_q.delete();
        if (slen == 0 || rlen == 0) begin
            flush_window();
            put_byte(item.text_byte);
        end else begin
            if (win_fill >= WIN_DEPTH) begin
                put_byte(win[0]);
                drop_oldest(1);
            end
            win[win_fill] = item.text_byte;
            win_fill++;
            if (win_fill >= slen) begin
                hit = 1'b1;
                for (i = 0; i < slen; i++)
                    if (win[i] != pattern_r[8*i +: 8]) hit = 1'b0;
                if (hit) begin
                    for (i = 0; i < rlen; i++) put_byte(replace_r[8*i +: 8]);
                    drop_oldest(slen);
                end else begin
                    put_byte(win[0]);
                    drop_oldest(1);
                end
            end
            if (item.text_end) flush_window();
        end
        // one beat never causes more than a full burst
        while (burst_q.size() > BURST_MAX) void'(burst_q.pop_back());
        if (item.text_end && burst_q.size() > 0)
            burst_q[burst_q.size() - 1].out_end = 1'b1;
        foreach (burst_q[i]) rewritten_q.push_back(burst_q[i]);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            pattern_r = '0;
            replace_r = '0;
            slen_r    = '0;
            rlen_r    = '0;
            foreach (win[i]) win[i] = '0;
            win_fill  = 0;
            rewritten_q.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (rewritten_q.size() == 0) begin
                    $error("unexpected output beat: out_byte=%02h out_end=%0b",
                           m_data.out_byte, m_data.out_end);
                    mismatch_count++;
                end else begin
                    want = rewritten_q.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte mismatch: expected %02h, got %02h",
                               want.out_byte, m_data.out_byte);
                        mismatch_count++;
                    end
                    if (m_data.out_end !== want.out_end) begin
                        $error("out_end mismatch: expected %0b, got %0b",
                               want.out_end, m_data.out_end);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SEARCH_PATTERN: pattern_r = cfg_wdata;
                    CFG_SEARCH_LEN: begin
                        slen_r   = cfg_wdata[3:0];
                        win_fill = 0;
                    end
                    CFG_REPLACE_BYTES:  replace_r = cfg_wdata;
                    CFG_REPLACE_LEN:    rlen_r = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) rewrite_byte(s_data);
        end
        bytes_outstanding <= rewritten_q.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level for the stream search-and-replace block
// Drives directed texts (register extremes, clamped lengths, replace length
// cleared and search length rewritten in mid text) and then random texts
// seeded with the search pattern under many register settings, with random
// gaps, output stalls and one long output hold-off. The checker beside the
// block predicts and compares; this module only drives and reports.
// ----------------------------------------------------------------------------
module tb;
    import ssr_pkg::*;

    localparam int TEXT_BEATS     = 230;
    localparam int PHASE_BEATS    = 25;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 8;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_index_t            cfg_index = CFG_SEARCH_PATTERN;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;

    int mismatch_count;
    int bytes_outstanding;

    bit          s_gaps_on     = 1'b1;
    bit          m_stalls_on   = 1'b1;
    int          holdoff_asked = 0;
    int          holdoff_served = 0;
    int          beats_sent    = 0;
    logic [63:0] cur_pattern   = '0;
    int          pat_span      = 0;

    stream_search_replace DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    ssr_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data            (m_data),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver: random stall before each beat, long hold-off on request.
    initial begin
        int stall;
        forever begin
            if (holdoff_asked != holdoff_served) begin
                m_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                holdoff_served++;
            end
            stall = m_stalls_on ? $urandom_range(0, 12) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = s_gaps_on ? $urandom_range(0, 12) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{text_byte: b, text_end: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    // Wait until every expected beat is out, then let the front end settle.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (bytes_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_regs(input logic [63:0] pat, input logic [3:0] slen,
                             input logic [63:0] rep, input logic [3:0] rlen);
        put_reg(CFG_SEARCH_PATTERN, pat);
        put_reg(CFG_SEARCH_LEN, {60'd0, slen});
        put_reg(CFG_REPLACE_BYTES, rep);
        put_reg(CFG_REPLACE_LEN, {60'd0, rlen});
        cfg_wr_en   <= 1'b0;
        cur_pattern  = pat;
        pat_span     = (slen > MAX_SEARCH_DEF) ? MAX_SEARCH_DEF : int'(slen);
    endtask

    // Build a text from whole patterns, partial patterns, pattern bytes and
    // noise, then send it with the end flag on its last beat.
    task automatic send_text(input int span);
        logic [7:0] text[$];
        int         plen;
        int         cut;
        int         k;
        plen = (pat_span == 0) ? 4 : pat_span;
        while (text.size() < span) begin
            case ($urandom_range(0, 3))
                0: for (k = 0; k < plen; k++) text.push_back(cur_pattern[8*k +: 8]);
                1: begin
                    cut = $urandom_range(1, plen);
                    for (k = 0; k < cut; k++) text.push_back(cur_pattern[8*k +: 8]);
                end
                2: text.push_back(8'($urandom_range(0, 255)));
                default: text.push_back(cur_pattern[8*$urandom_range(0, plen - 1) +: 8]);
            endcase
        end
        while (text.size() > span) void'(text.pop_back());
        foreach (text[i]) send_beat(text[i], i == text.size() - 1);
    endtask

    initial begin
        int          phase;
        int          phase_start;
        logic [3:0]  slen_v;
        logic [3:0]  rlen_v;
        logic [7:0]  fill;
        logic [63:0] pat_v;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers at reset: plain pass through, byte extremes
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        drain();

        // "AB" -> "XYZ", hits at the start and at the very end of the text
        load_regs(64'h4241, 4'd2, 64'h5A5958, 4'd3);
        send_beat(8'h41, 1'b0);
        send_beat(8'h42, 1'b0);
        send_beat(8'h43, 1'b0);
        send_beat(8'h41, 1'b0);
        send_beat(8'h41, 1'b0);
        send_beat(8'h42, 1'b1);
        drain();

        // oversized lengths clamp to a full 8-byte search and replacement
        load_regs(64'h8877665544332211, 4'd15, 64'hFFEEDDCCBBAA9988, 4'd12);
        for (int i = 1; i <= 8; i++) send_beat(8'(i * 8'h11), 1'b0);
        send_beat(8'h5A, 1'b1);
        drain();

        // replace length cleared with bytes pending: they come out first
        load_regs(64'h636261, 4'd3, 64'h2A, 4'd1);
        send_beat(8'h61, 1'b0);
        send_beat(8'h62, 1'b0);
        drain();
        put_reg(CFG_REPLACE_LEN, '0);
        cfg_wr_en <= 1'b0;
        send_beat(8'h63, 1'b0);
        send_beat(8'h78, 1'b1);
        drain();

        // search length rewritten with bytes pending: they are dropped
        load_regs(64'h636261, 4'd3, 64'h2A2A, 4'd2);
        send_beat(8'h61, 1'b0);
        send_beat(8'h62, 1'b0);
        drain();
        put_reg(CFG_SEARCH_LEN, 64'd3);
        cfg_wr_en <= 1'b0;
        send_beat(8'h63, 1'b1);
        drain();

        phase = 0;
        while (beats_sent < TEXT_BEATS) begin
            case (phase)
                0: begin slen_v = 4'd1; rlen_v = 4'd8; end
                1: begin slen_v = 4'd8; rlen_v = 4'd1; end
                2: begin slen_v = 4'd8; rlen_v = 4'd8; end
                3: begin slen_v = 4'd0; rlen_v = 4'($urandom_range(1, 8)); end
                4: begin slen_v = 4'($urandom_range(1, 8)); rlen_v = 4'd0; end
                default: begin
                    slen_v = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                         : 4'($urandom_range(1, 8));
                    rlen_v = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(1, 8));
                end
            endcase
            // a single repeated byte exercises overlapping candidates
            fill  = 8'($urandom);
            pat_v = ($urandom_range(0, 3) == 0) ? {8{fill}} : {$urandom, $urandom};
            load_regs(pat_v, slen_v, {$urandom, $urandom}, rlen_v);

            if (phase == 2) begin
                // back-to-back beats against a stalled output
                s_gaps_on   = 1'b0;
                m_stalls_on = 1'b0;
                holdoff_asked++;
            end else begin
                s_gaps_on   = ($urandom_range(0, 2) != 0);
                m_stalls_on = ($urandom_range(0, 2) != 0);
            end

            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
                send_text($urandom_range(1, 20));
            drain();
            phase++;
        end

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
